// ----- hw/rtl/keyframe_pose_interpolator_unit_defines.svh -----
// Assertion helpers for the keyframe pose interpolator.
`ifndef KEYFRAME_POSE_INTERPOLATOR_UNIT_DEFINES_SVH
`define KEYFRAME_POSE_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define KPI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define KPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/kpi_pkg.sv -----
`default_nettype none
package kpi_pkg;
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 26;
	localparam int FL_W   = 10;
	localparam int ROW_W  = 3 * VAL_W;

	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_COUNT = 3'd1;
	localparam logic [2:0] MODE_FRAME = 3'd2;
	localparam logic [2:0] MODE_POS   = 3'd3;
	localparam logic [2:0] MODE_ROT   = 3'd4;

	localparam logic REG_MOTION_SEL = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAME,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} kpi_state_t;

	typedef struct packed {
		logic                  start;
		logic [FL_W-1:0]       counter;
		logic [FL_W-1:0]       divisor;
	} kpi_div_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/kpi_store.sv -----
`default_nettype none
module kpi_store #(
	parameter int VDEPTH = 256,
	parameter int FDEPTH = 128
) (
	input  wire logic                              clk,
	input  wire logic                              vwe,
	input  wire logic [$clog2(VDEPTH)-1:0]         vwaddr,
	input  wire logic [kpi_pkg::ROW_W-1:0]         vwdata,
	input  wire logic [$clog2(VDEPTH)-1:0]         vraddr,
	output logic      [kpi_pkg::ROW_W-1:0]         vrdata,
	input  wire logic                              fwe,
	input  wire logic [$clog2(FDEPTH)-1:0]         fwaddr,
	input  wire logic [kpi_pkg::FL_W-1:0]          fwdata,
	input  wire logic [$clog2(FDEPTH)-1:0]         fraddr,
	output logic      [kpi_pkg::FL_W-1:0]          frdata
);
	// one row holds x, y, z of either position or rotation
	logic [kpi_pkg::ROW_W-1:0] vmem [VDEPTH];
	logic [kpi_pkg::FL_W-1:0]  fmem [FDEPTH];

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= vwdata;
		end
		vrdata <= vmem[vraddr];
	end

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwaddr] <= fwdata;
		end
		frdata <= fmem[fraddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/kpi_div.sv -----
`default_nettype none
module kpi_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kpi_pkg::kpi_div_req_t       req,
	output logic                             done,
	output logic [kpi_pkg::FRAC_W-1:0]       quot
);
	// restoring division of counter*65536 by the frame length, one bit a cycle
	logic [kpi_pkg::FRAC_W-1:0] dvd_q;
	logic [kpi_pkg::FL_W-1:0]   rem_q;
	logic [kpi_pkg::FL_W-1:0]   dsr_q;
	logic [4:0]                 cnt_q;
	logic                       run_q;
	logic [kpi_pkg::FL_W:0]     rem_sh;
	logic [kpi_pkg::FL_W:0]     rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, dvd_q[kpi_pkg::FRAC_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(kpi_pkg::FRAC_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {req.counter, 16'd0};
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[kpi_pkg::FRAC_W-2:0], ge};
			rem_q <= ge ? rem_sub[kpi_pkg::FL_W-1:0] : rem_sh[kpi_pkg::FL_W-1:0];
		end
	end

	assign quot = dvd_q;
endmodule
`default_nettype wire

// ----- hw/rtl/kpi_lerp.sv -----
`default_nettype none
module kpi_lerp (
	input  wire logic                              clk,
	input  wire logic signed [kpi_pkg::VAL_W-1:0]  a,
	input  wire logic signed [kpi_pkg::VAL_W-1:0]  b,
	input  wire logic [kpi_pkg::FRAC_W-1:0]        frac,
	output logic signed [kpi_pkg::VAL_W-1:0]       res
);
	localparam int DW = kpi_pkg::VAL_W + 1;
	localparam int PW = DW + kpi_pkg::FRAC_W + 1;
	localparam int SW = PW - 16 + 1;

	logic signed [DW-1:0]            delta;
	logic signed [PW-1:0]            prod_s1;
	logic signed [kpi_pkg::VAL_W-1:0] a_s1;
	logic signed [SW-1:0]            sum;

	assign delta = {b[kpi_pkg::VAL_W-1], b} - {a[kpi_pkg::VAL_W-1], a};

	// stage 1: product; stage 2: floor shift, add and saturate
	always_ff @(posedge clk) begin
		prod_s1 <= delta * $signed({1'b0, frac});
		a_s1    <= a;
	end

	assign sum = SW'(a_s1) + SW'(prod_s1 >>> 16);

	always_ff @(posedge clk) begin
		if (sum > SW'(32'sh7fffffff)) begin
			res <= 32'sh7fffffff;
		end else if (sum < -SW'(33'sh080000000)) begin
			res <= 32'sh80000000;
		end else begin
			res <= sum[kpi_pkg::VAL_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/keyframe_pose_interpolator_unit.sv -----
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+----------------------------
// item in   | mode motion_index key_index key_count          | start while busy is low
//           | frame_length val_x val_y val_z                 |
// result    | pos_x..z rot_x..z key_used tick_in_key         | done, one cycle, no stall
// config    | psel penable pwrite paddr pwdata prdata pready | APB, motion_select at 0x0
//
// Write items never raise busy. A tick runs from acceptance to the done cycle
// through one frame-length read, the serial divider (26 shift steps and its
// done cycle; the value-row reads overlap it), the shared two-stage multiplier
// for the six channels and the done cycle itself; the next item can be taken
// in the cycle after done. A tick on an empty motion never raises busy.
// Reset clears key counts, current key, counter and motion_select; the tables
// hold garbage until written. The receiver cannot stall; results are not held.
`default_nettype none
`include "keyframe_pose_interpolator_unit_defines.svh"
module keyframe_pose_interpolator_unit #(
	parameter int NUM_MOTIONS = 8,
	parameter int MAX_KEYS    = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         mode,
	input  wire logic [2:0]         motion_index,
	input  wire logic [3:0]         key_index,
	input  wire logic [4:0]         key_count,
	input  wire logic [9:0]         frame_length,
	input  wire logic signed [31:0] val_x,
	input  wire logic signed [31:0] val_y,
	input  wire logic signed [31:0] val_z,
	output logic                    done,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      rot_x,
	output logic signed [31:0]      rot_y,
	output logic signed [31:0]      rot_z,
	output logic [3:0]              key_used,
	output logic [9:0]              tick_in_key,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	localparam int MW     = (NUM_MOTIONS > 1) ? $clog2(NUM_MOTIONS) : 1;
	localparam int KW     = $clog2(MAX_KEYS);
	localparam int CW     = $clog2(MAX_KEYS + 1);
	localparam int VDEPTH = NUM_MOTIONS * MAX_KEYS * 2;
	localparam int FDEPTH = NUM_MOTIONS * MAX_KEYS;
	localparam int VAW    = $clog2(VDEPTH);
	localparam int FAW    = $clog2(FDEPTH);
	localparam int VW     = kpi_pkg::VAL_W;

	kpi_pkg::kpi_state_t state_q, state_d;

	logic [2:0]               msel_q;
	logic [CW-1:0]            kcnt_q [NUM_MOTIONS];
	logic [KW-1:0]            key_q;
	logic [kpi_pkg::FL_W-1:0] cnt_q;
	logic [KW-1:0]            cur_q, nxt_q;
	logic [CW-1:0]            n_q;
	logic [kpi_pkg::FL_W-1:0] frame_q;
	logic [2:0]               ld_q;
	logic [2:0]               mc_q;
	logic [kpi_pkg::ROW_W-1:0] row_q [4];
	logic [VW-1:0]            res_q [6];

	logic                     accept, msel_ok, mi_ok, ki_ok, tick_go;
	logic [MW-1:0]            msel_idx, mi_idx;
	logic [CW-1:0]            n_w;
	logic [KW-1:0]            cur_w, nxt_w;
	logic [CW:0]              cur_inc;
	logic [kpi_pkg::FL_W-1:0] frame_w;
	logic [kpi_pkg::FL_W:0]   cnt_inc;

	logic                      vwe, fwe;
	logic [VAW-1:0]            vwaddr, vraddr;
	logic [kpi_pkg::ROW_W-1:0] vwdata, vrdata;
	logic [FAW-1:0]            fwaddr, fraddr;
	logic [kpi_pkg::FL_W-1:0]  frdata;

	kpi_pkg::kpi_div_req_t     div_req;
	logic                      div_done;
	logic [kpi_pkg::FRAC_W-1:0] frac;

	logic [2:0]                ch;
	logic signed [VW-1:0]      la, lb, lres;

	// ---------------- acceptance and decode ----------------
	assign busy     = state_q != kpi_pkg::ST_IDLE;
	assign accept   = start && !busy;
	assign msel_idx = MW'(msel_q);
	assign mi_idx   = MW'(motion_index);
	assign msel_ok  = 32'(msel_q) < NUM_MOTIONS;
	assign mi_ok    = 32'(motion_index) < NUM_MOTIONS;
	assign ki_ok    = 32'(key_index) < MAX_KEYS;
	assign n_w      = msel_ok ? kcnt_q[msel_idx] : '0;
	// a stale key wraps to zero before use
	assign cur_w    = ({{(CW-KW){1'b0}}, key_q} >= n_w) ? '0 : key_q;
	assign cur_inc  = {1'b0, {(CW-KW){1'b0}}, cur_w} + (CW+1)'(1);
	assign nxt_w    = (cur_inc >= {1'b0, n_w}) ? '0 : KW'(cur_inc);
	assign tick_go  = accept && mode == kpi_pkg::MODE_TICK && msel_ok && n_w != '0;

	// ---------------- table writes ----------------
	assign vwe    = accept && mi_ok && ki_ok &&
		(mode == kpi_pkg::MODE_POS || mode == kpi_pkg::MODE_ROT);
	assign vwaddr = VAW'((int'(mi_idx) * MAX_KEYS + int'(KW'(key_index))) * 2 +
		((mode == kpi_pkg::MODE_ROT) ? 1 : 0));
	assign vwdata = {val_z, val_y, val_x};
	assign fwe    = accept && mi_ok && ki_ok && mode == kpi_pkg::MODE_FRAME;
	assign fwaddr = FAW'(int'(mi_idx) * MAX_KEYS + int'(KW'(key_index)));
	// frame length of the current key, read in the accept cycle
	assign fraddr = FAW'(int'(msel_idx) * MAX_KEYS + int'(cur_w));

	// row reads during the division: cur pos, cur rot, next pos, next rot
	assign vraddr = VAW'((int'(msel_idx) * MAX_KEYS + int'(ld_q[1] ? nxt_q : cur_q)) * 2 +
		int'(ld_q[0]));

	kpi_store #(
		.VDEPTH (VDEPTH),
		.FDEPTH (FDEPTH)
	) u_store (
		.clk    (clk),
		.vwe    (vwe),
		.vwaddr (vwaddr),
		.vwdata (vwdata),
		.vraddr (vraddr),
		.vrdata (vrdata),
		.fwe    (fwe),
		.fwaddr (fwaddr),
		.fwdata (frame_length),
		.fraddr (fraddr),
		.frdata (frdata)
	);

	// zero frame length counts as one
	assign frame_w = (frdata == '0) ? kpi_pkg::FL_W'(1) : frdata;

	assign div_req.start   = state_q == kpi_pkg::ST_FRAME;
	assign div_req.counter = cnt_q;
	assign div_req.divisor = frame_w;

	kpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (frac)
	);

	// channel feed: 0..2 position, 3..5 rotation
	assign ch = mc_q;
	always_comb begin
		la = '0;
		lb = '0;
		case (ch)
			3'd0: begin la = row_q[0][VW-1:0];      lb = row_q[2][VW-1:0];      end
			3'd1: begin la = row_q[0][2*VW-1:VW];   lb = row_q[2][2*VW-1:VW];   end
			3'd2: begin la = row_q[0][3*VW-1:2*VW]; lb = row_q[2][3*VW-1:2*VW]; end
			3'd3: begin la = row_q[1][VW-1:0];      lb = row_q[3][VW-1:0];      end
			3'd4: begin la = row_q[1][2*VW-1:VW];   lb = row_q[3][2*VW-1:VW];   end
			3'd5: begin la = row_q[1][3*VW-1:2*VW]; lb = row_q[3][3*VW-1:2*VW]; end
			default: begin la = '0; lb = '0; end
		endcase
	end

	kpi_lerp u_lerp (
		.clk  (clk),
		.a    (la),
		.b    (lb),
		.frac (frac),
		.res  (lres)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			kpi_pkg::ST_IDLE:  if (tick_go) state_d = kpi_pkg::ST_FRAME;
			kpi_pkg::ST_FRAME: state_d = kpi_pkg::ST_DIV;
			kpi_pkg::ST_DIV:   if (div_done) state_d = kpi_pkg::ST_MUL;
			kpi_pkg::ST_MUL:   if (mc_q == 3'd7) state_d = kpi_pkg::ST_DONE;
			kpi_pkg::ST_DONE:  state_d = kpi_pkg::ST_IDLE;
			default:           state_d = kpi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + (kpi_pkg::FL_W+1)'(1);

	// control registers: key counts, play position, step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTIONS; i++) begin
				kcnt_q[i] <= '0;
			end
			key_q <= '0;
			cnt_q <= '0;
			ld_q  <= '0;
			mc_q  <= '0;
		end else begin
			if (accept && mode == kpi_pkg::MODE_COUNT && mi_ok) begin
				kcnt_q[mi_idx] <= (32'(key_count) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count);
			end
			case (state_q)
				kpi_pkg::ST_FRAME: ld_q <= '0;
				kpi_pkg::ST_DIV: begin
					if (ld_q != 3'd5) ld_q <= ld_q + 3'd1;
					mc_q <= '0;
				end
				kpi_pkg::ST_MUL: mc_q <= mc_q + 3'd1;
				kpi_pkg::ST_DONE: begin
					// advance the counter; end the key when its frame is used up
					if (cnt_inc >= {1'b0, frame_q}) begin
						cnt_q <= '0;
						key_q <= nxt_q;
					end else begin
						cnt_q <= cnt_inc[kpi_pkg::FL_W-1:0];
						key_q <= cur_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (tick_go) begin
			cur_q <= cur_w;
			nxt_q <= nxt_w;
			n_q   <= n_w;
		end
		if (state_q == kpi_pkg::ST_FRAME) begin
			frame_q <= frame_w;
		end
		if (state_q == kpi_pkg::ST_DIV && ld_q != 3'd0 && ld_q != 3'd5) begin
			row_q[2'(ld_q - 3'd1)] <= vrdata;
		end
		if (state_q == kpi_pkg::ST_MUL && mc_q >= 3'd2) begin
			res_q[3'(mc_q - 3'd2)] <= lres;
		end
	end

	// ---------------- result and register port ----------------
	assign done        = state_q == kpi_pkg::ST_DONE;
	assign pos_x       = res_q[0];
	assign pos_y       = res_q[1];
	assign pos_z       = res_q[2];
	assign rot_x       = res_q[3];
	assign rot_y       = res_q[4];
	assign rot_z       = res_q[5];
	assign key_used    = 4'(cur_q);
	assign tick_in_key = cnt_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kpi_pkg::REG_MOTION_SEL) ? {29'd0, msel_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msel_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == kpi_pkg::REG_MOTION_SEL) begin
			msel_q <= pwdata[2:0];
		end
	end

	// ---------------- checks ----------------
	`KPI_ASSERT_NOW(a_key_in_range, done, {{(CW-KW){1'b0}}, cur_q} < n_q, "key beyond count")
	`KPI_ASSERT_NEXT(a_one_result, done, !done && !busy, "result repeated or stuck busy")
	`KPI_ASSERT_NEXT(a_write_quick, accept && mode != kpi_pkg::MODE_TICK, !busy,
		"write item raised busy")
	`KPI_ASSERT_NEXT(a_tick_busy, tick_go, busy, "tick not started")
endmodule
`default_nettype wire
